// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== design/dip_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal integer parser package
// Request types, number kind codes and parsing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dip_pkg;

    // Number kind codes held in the configuration register.
    localparam logic [1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [1:0] KIND_BYTE     = 2'd1;
    localparam logic [1:0] KIND_SIGNED   = 2'd2;

    localparam int unsigned ACC_W = 33;

    // Bounds checked before each digit and at the end of a byte field.
    localparam logic [ACC_W-1:0] LIMIT_UNSIGNED = 33'd107374180;
    localparam logic [ACC_W-1:0] LIMIT_SIGNED   = 33'd536870000;
    localparam logic [ACC_W-1:0] BYTE_BOUND     = 33'd256;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Input request: one character of a field.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       empty_field;
    } char_req_t;

    // Output request: one parsed field.
    typedef struct packed {
        logic             accepted;
        logic [ACC_W-1:0] magnitude;
        logic             negative;
    } result_req_t;

    // Classified character as it travels through the queue.
    typedef struct packed {
        logic       is_digit;
        logic [3:0] digit;
        logic       is_minus;
        logic       last;
        logic       empty_field;
    } char_class_t;

endpackage

`default_nettype wire

// ===== design/decimal_integer_parser_unit.sv =====
// A field's result passes through the queue and then the back end's output register.
// One character per cycle while the queue has room; the multiply-by-ten accumulate is combinational.
// The queue between front and back absorbs output stalls of up to QUEUE_DEPTH characters.
// Reset: rst_n clears the queue, the field state and the kind register (unsigned, below 2^30).
// No clearing pass is needed; the block takes characters right after reset.
// ----------------------------------------------------------------------------
// Decimal integer parser unit
// Parses ASCII decimal fields one character per cycle, while the queue has room, with range checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module decimal_integer_parser_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_write_en,
    input  wire [1:0]            cfg_write_data,
    input  wire                  char_valid,
    output logic                 char_stall,
    input  dip_pkg::char_req_t   char_data,
    output logic                 result_valid,
    input  wire                  result_stall,
    output dip_pkg::result_req_t result_data
);
    import dip_pkg::*;

    logic [1:0]   kind_reg;
    char_class_t  front_class;
    char_class_t  head_data;
    logic         queue_full;
    logic         head_valid;
    logic         pop;
    logic         push;

    // Number kind configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_UNSIGNED;
        end
        else if (cfg_write_en)
        begin
            kind_reg <= cfg_write_data;
        end
    end

    // Characters are taken while the queue has room.
    assign char_stall = queue_full;
    assign push       = char_valid && !queue_full;

    dip_front u_front (
        .char_data  (char_data),
        .char_class (front_class)
    );

    dip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_class),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    dip_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_kind  (kind_reg),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

// ===== design/dip_front.sv =====
// ----------------------------------------------------------------------------
// Decimal integer parser front end
// Classifies each incoming character before it enters the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dip_front (
    input  dip_pkg::char_req_t   char_data,
    output dip_pkg::char_class_t char_class
);
    import dip_pkg::*;

    logic [7:0] char_offset;

    // Digit detection and value extraction.
    always_comb
    begin
        char_offset            = char_data.character - CHAR_ZERO;
        char_class.is_digit    = (char_data.character >= CHAR_ZERO) &&
                                 (char_data.character <= CHAR_NINE);
        char_class.digit       = char_offset[3:0];
        char_class.is_minus    = (char_data.character == CHAR_MINUS);
        char_class.last        = char_data.last;
        char_class.empty_field = char_data.empty_field;
    end

endmodule

`default_nettype wire

// ===== design/dip_queue.sv =====
// ----------------------------------------------------------------------------
// Decimal integer parser queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dip_queue #(
    parameter int DEPTH = 2
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  dip_pkg::char_class_t  push_data,
    input  wire                   pop,
    output logic                  full,
    output logic                  head_valid,
    output dip_pkg::char_class_t  head_data
);
    import dip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    char_class_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    // Status and pointer updates.
    always_comb
    begin
        full        = (count_reg == FULL_CNT);
        head_valid  = (count_reg != '0);
        head_data   = entry_reg[rd_ptr_reg];
        wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never exceeds the depth.
    `ASSERT_ALWAYS(a_count_bound, clk, !rst_n || count_reg <= FULL_CNT, "queue count above depth")
    // A lone push grows the fill count by one.
    `ASSERT_CLK(a_push_grows, clk, rst_n, push && !pop |=> count_reg == CNT_W'($past(count_reg) + 1'b1), "queue count did not grow on push")

endmodule

`default_nettype wire

// ===== design/dip_back.sv =====
// ----------------------------------------------------------------------------
// Decimal integer parser back end
// Accumulates digits, tracks field state and registers each field result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dip_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire [1:0]             number_kind,
    input  wire                   head_valid,
    input  dip_pkg::char_class_t  head_data,
    output logic                  pop,
    output logic                  result_valid,
    input  wire                   result_stall,
    output dip_pkg::result_req_t  result_data
);
    import dip_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic             at_start_reg;
    logic             at_start_next;
    logic             rejected_reg;
    logic             rejected_next;
    logic             minus_reg;
    logic             minus_next;
    logic             digit_seen_reg;
    logic             digit_seen_next;
    logic             result_valid_reg;
    result_req_t      result_data_reg;
    result_req_t      result_data_next;

    logic             ends_field;
    logic [ACC_W-1:0] limit;
    logic [ACC_W-1:0] acc_times_ten;
    logic             field_ok;

    // Character step: minus, limit check, digit check and accumulate.
    always_comb
    begin
        ends_field      = head_data.last || head_data.empty_field;
        pop             = head_valid && (!ends_field || !result_valid_reg || !result_stall);
        limit           = (number_kind == KIND_SIGNED) ? LIMIT_SIGNED : LIMIT_UNSIGNED;
        acc_times_ten   = (acc_reg << 3) + (acc_reg << 1);
        acc_next        = acc_reg;
        at_start_next   = 1'b0;
        rejected_next   = rejected_reg;
        minus_next      = minus_reg;
        digit_seen_next = digit_seen_reg;
        if (!rejected_reg)
        begin
            if (at_start_reg && (number_kind == KIND_SIGNED) && head_data.is_minus)
            begin
                minus_next = 1'b1;
            end
            else if (acc_reg >= limit || !head_data.is_digit)
            begin
                rejected_next = 1'b1;
            end
            else
            begin
                acc_next        = acc_times_ten + ACC_W'(head_data.digit);
                digit_seen_next = 1'b1;
            end
        end

        // End of field verdict; an empty field is always rejected.
        field_ok = !rejected_next && digit_seen_next && !head_data.empty_field &&
                   !((number_kind == KIND_BYTE) && (acc_next >= BYTE_BOUND));
        result_data_next.accepted  = field_ok;
        result_data_next.magnitude = field_ok ? acc_next : '0;
        result_data_next.negative  = field_ok && minus_next;
    end

    // Field state registers; a finished field returns to its start state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            at_start_reg   <= 1'b1;
            rejected_reg   <= 1'b0;
            minus_reg      <= 1'b0;
            digit_seen_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (ends_field)
            begin
                acc_reg        <= '0;
                at_start_reg   <= 1'b1;
                rejected_reg   <= 1'b0;
                minus_reg      <= 1'b0;
                digit_seen_reg <= 1'b0;
            end
            else
            begin
                acc_reg        <= acc_next;
                at_start_reg   <= at_start_next;
                rejected_reg   <= rejected_next;
                minus_reg      <= minus_next;
                digit_seen_reg <= digit_seen_next;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (pop && ends_field)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (pop && ends_field)
        begin
            result_data_reg <= result_data_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // A finished field always leaves a result waiting.
    `ASSERT_CLK(a_end_gives_result, clk, rst_n, pop && ends_field |=> result_valid_reg, "field end without result")
    // A finished field clears the field state.
    `ASSERT_CLK(a_end_clears, clk, rst_n, pop && ends_field |=> at_start_reg && !rejected_reg && acc_reg == '0, "field state not cleared")

endmodule

`default_nettype wire

// ===== dv/decimal_integer_parser_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Decimal integer parser unit testbench
// Streams text fields into the parser one character per request and checks
// every parsed field against a cycle-free predictor kept in a scoreboard.
// Covers all number kinds (the spare code included), kind changes in the
// middle of a field, limit and byte bounds, and output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_integer_parser_unit_tb;
    import dip_pkg::*;

    // The fourth kind code has no name in the package; it parses as unsigned.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int IDLE_PCT      = 17;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 240;

    typedef logic [7:0] text_t[$];

    // Predicts the parse result of each field and checks the unit's results.
    class parse_scoreboard;
        logic [1:0]       kind;
        logic [ACC_W-1:0] acc;
        bit               at_start;
        bit               rejected;
        bit               minus_seen;
        bit               digit_seen;
        result_req_t      expected_fields[$];
        int               errors;

        function new();
            kind   = KIND_UNSIGNED;
            errors = 0;
            clear_field();
        endfunction

        function void clear_field();
            acc        = '0;
            at_start   = 1'b1;
            rejected   = 1'b0;
            minus_seen = 1'b0;
            digit_seen = 1'b0;
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction

        // Notes one accepted character request; a field end queues a result.
        function void note_char(char_req_t req);
            result_req_t      res;
            logic [ACC_W-1:0] limit;
            logic [7:0]       digit;
            bit               first;
            bit               ok;
            if (req.empty_field)
            begin
                res = '0;
                expected_fields.push_back(res);
                clear_field();
                return;
            end
            first    = at_start;
            at_start = 1'b0;
            if (!rejected)
            begin
                limit = (kind == KIND_SIGNED) ? LIMIT_SIGNED : LIMIT_UNSIGNED;
                digit = req.character - CHAR_ZERO;
                if (first && kind == KIND_SIGNED && req.character == CHAR_MINUS)
                    minus_seen = 1'b1;
                else if (acc >= limit)
                    rejected = 1'b1;
                else if (req.character < CHAR_ZERO || req.character > CHAR_NINE)
                    rejected = 1'b1;
                else
                begin
                    acc        = acc * 10 + digit;
                    digit_seen = 1'b1;
                end
            end
            if (!req.last)
                return;
            ok = !rejected && digit_seen;
            // The byte bound uses the kind in force when the field ends.
            if (ok && kind == KIND_BYTE && acc >= BYTE_BOUND)
                ok = 1'b0;
            res.accepted  = ok;
            res.magnitude = ok ? acc : '0;
            res.negative  = ok && minus_seen;
            expected_fields.push_back(res);
            clear_field();
        endfunction

        // Compares one accepted result request with the oldest expectation.
        function void check_result(result_req_t got);
            result_req_t exp;
            if (expected_fields.size() == 0)
            begin
                $display("%0t: unexpected result accepted=%0d magnitude=%0d negative=%0d",
                         $time, got.accepted, got.magnitude, got.negative);
                errors++;
                return;
            end
            exp = expected_fields.pop_front();
            if (got.accepted !== exp.accepted)
            begin
                $display("%0t: accepted mismatch: expected %0d, actual %0d",
                         $time, exp.accepted, got.accepted);
                errors++;
            end
            if (got.magnitude !== exp.magnitude)
            begin
                $display("%0t: magnitude mismatch: expected %0d, actual %0d",
                         $time, exp.magnitude, got.magnitude);
                errors++;
            end
            if (got.negative !== exp.negative)
            begin
                $display("%0t: negative mismatch: expected %0d, actual %0d",
                         $time, exp.negative, got.negative);
                errors++;
            end
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [1:0]  cfg_write_data = KIND_UNSIGNED;
    logic        char_valid     = 1'b0;
    logic        char_stall;
    char_req_t   char_data      = '0;
    logic        result_valid;
    logic        result_stall   = 1'b0;
    result_req_t result_data;

    // Set for a stretch in which neither side idles.
    bit quiet         = 1'b0;
    // Asks the receiver for one long hold-off.
    bit hold_results  = 1'b0;
    int items_sent    = 0;

    parse_scoreboard board;

    decimal_integer_parser_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_data      (char_data),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result_data    (result_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("decimal_integer_parser_unit_tb: FAIL");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off when asked.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result monitor; inputs are stable from the falling edge to the next rise.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid && !result_stall)
                board.check_result(result_data);
        end
    end

    // Offers one character request and returns at the edge that takes it.
    task automatic send_item(input char_req_t item);
        bit taken;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= item;
        do
        begin
            @(negedge clk);
            taken = !char_stall;
            @(posedge clk);
        end while (!taken);
        board.note_char(item);
        items_sent++;
    endtask

    task automatic send_empty();
        char_req_t item;
        item.character   = 8'($urandom_range(255));
        item.last        = 1'($urandom_range(1));
        item.empty_field = 1'b1;
        send_item(item);
    endtask

    // Sends the characters of a field; close marks the final one as last.
    task automatic send_text(input text_t f, input bit close);
        char_req_t item;
        if (f.size() == 0 && close)
        begin
            send_empty();
            return;
        end
        for (int i = 0; i < f.size(); i++)
        begin
            item.character   = f[i];
            item.last        = close && (i == f.size() - 1);
            item.empty_field = 1'b0;
            send_item(item);
        end
    endtask

    task automatic send_string(input string s, input bit close);
        text_t f;
        foreach (s[i])
            f.push_back(s[i]);
        send_text(f, close);
    endtask

    // Stops offering, waits for every expected result, then lets the pipe drain.
    task automatic drain_and_settle();
        char_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_kind(input logic [1:0] k);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= k;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        board.kind = k;
    endtask

    // Builds one random field: mostly numbers, some near the limits, some noise.
    function automatic text_t make_field(input logic [1:0] kind);
        text_t           f;
        string           s;
        int              roll;
        int              n;
        longint unsigned v;
        longint unsigned span;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            n = $urandom_range(1, 6);
            repeat (n) f.push_back(8'($urandom_range(255)));
            return f;
        end
        if (roll < 30)
            v = ((kind == KIND_SIGNED) ? 64'd5368699990 :
                 (kind == KIND_BYTE)   ? 64'd250 : 64'd1073741790) + $urandom_range(20);
        else if (kind == KIND_BYTE)
            v = $urandom_range(400);
        else
        begin
            n    = $urandom_range(1, 11);
            span = 1;
            repeat (n) span = span * 10;
            v = {$urandom, $urandom} % span;
        end
        if ($urandom_range(99) < ((kind == KIND_SIGNED) ? 40 : 8))
            f.push_back(CHAR_MINUS);
        // Leading zeros leave the value unchanged.
        if (roll >= 30 && roll < 38)
        begin
            f.push_back(CHAR_ZERO);
            f.push_back(CHAR_ZERO);
        end
        s = $sformatf("%0d", v);
        foreach (s[i])
            f.push_back(s[i]);
        // A stray character somewhere breaks the field.
        if ($urandom_range(99) < 5)
            f.insert($urandom_range(f.size() - 1), 8'($urandom_range(255)));
        return f;
    endfunction

    task automatic run_directed();
        // Unsigned kind after reset: bounds, non-digits and empty fields.
        send_string("0", 1);
        send_string("1073741799", 1);
        send_string("1073741809", 1);
        send_string("12a", 1);
        send_string("/:", 1);
        send_item('{8'hFF, 1'b1, 1'b0});
        send_item('{8'h00, 1'b1, 1'b0});
        send_string("-5", 1);
        send_empty();
        // An empty field while a field is partly taken discards it.
        send_string("12", 0);
        send_empty();
        drain_and_settle();
        write_kind(KIND_BYTE);
        send_string("255", 1);
        send_string("256", 1);
        drain_and_settle();
        write_kind(KIND_SIGNED);
        send_string("-0", 1);
        send_string("-", 1);
        send_string("5-", 1);
        send_string("--1", 1);
        send_string("-5368699999", 1);
        send_string("5368700000", 1);
        drain_and_settle();
        write_kind(KIND_SPARE);
        send_string("-1", 1);
        send_string("4294967295", 1);
        drain_and_settle();
        // Kind changed in the middle of a field: the minus was taken as signed.
        write_kind(KIND_SIGNED);
        send_string("-12", 0);
        drain_and_settle();
        write_kind(KIND_UNSIGNED);
        send_string("3", 1);
        // The byte bound applies with the kind in force at the end.
        send_string("300", 0);
        drain_and_settle();
        write_kind(KIND_BYTE);
        send_string("0", 1);
        drain_and_settle();
    endtask

    task automatic run_random();
        logic [1:0] kinds[8];
        text_t      f;
        int         start;
        int         roll;
        kinds = '{KIND_UNSIGNED, KIND_BYTE, KIND_SIGNED, KIND_SPARE,
                  KIND_SIGNED, KIND_UNSIGNED, KIND_BYTE, KIND_SIGNED};
        for (int p = 0; p < 8; p++)
        begin
            write_kind(kinds[p]);
            quiet = (p == 2);
            // Long output hold-off while short fields keep coming.
            if (p == 4)
            begin
                hold_results = 1'b1;
                repeat (30) send_string($sformatf("%0d", $urandom_range(9)), 1);
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 4)
                    send_empty();
                else
                begin
                    f = make_field(kinds[p]);
                    if (roll < 8 && f.size() > 1)
                    begin
                        f.pop_back();
                        send_text(f, 1'b0);
                        send_empty();
                    end
                    else
                        send_text(f, 1'b1);
                end
            end
            quiet = 1'b0;
            drain_and_settle();
        end
    endtask

    // Main sequence.
    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        drain_and_settle();
        if (board.errors == 0)
            $display("decimal_integer_parser_unit_tb: PASS");
        else
            $display("decimal_integer_parser_unit_tb: FAIL");
        $finish;
    end

endmodule
